// ===== hdl/perspective_world_to_screen_macros.svh =====
// assertion macros shared by the checker
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pws_pkg.sv =====
`timescale 1ns / 1ps
package pws_pkg;

    localparam int POS_W    = 32;
    localparam int OUT_W    = 24;
    localparam int NUM_REGS = 8;
    localparam int CFG_IW   = 8;
    localparam int CFG_DW   = 64;
    localparam int SUM_W    = 50;
    localparam int QW       = 24;

    localparam logic signed [SUM_W-1:0] NEAR_Q16   = 50'sd6554;
    localparam logic signed [OUT_W-1:0] HIDDEN_VAL = -24'sd256;
    localparam logic signed [OUT_W-1:0] OUT_MAX    = 24'sh7fffff;
    localparam logic signed [OUT_W-1:0] OUT_MIN    = 24'sh800000;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_t;

    typedef struct packed {
        logic                    visible;
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
    } out_t;

endpackage

// ===== hdl/pws_divider.sv =====
`timescale 1ns / 1ps
module pws_divider #(
    parameter int PW = 72,
    parameter int DW = 49
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [PW-1:0]                     prod,
    input  logic [DW-1:0]                     den,
    input  logic                              neg,
    output logic signed [pws_pkg::OUT_W-1:0]  q
);

    localparam int QW = pws_pkg::QW;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          neg_reg [0:QW];
    logic          sat_reg [0:QW];
    logic signed [pws_pkg::OUT_W-1:0] res_reg;

    logic [PW-1:0] hi;
    assign hi = prod >> QW;

    // quotient would need more than QW bits: saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= (hi >= PW'(den));
            rem_reg[0] <= hi[DW-1:0];
            low_reg[0] <= prod[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
        end
    end

    // one restoring step per stage
    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [DW:0] t;
        logic        ge;
        assign t  = {rem_reg[j-1], low_reg[j-1][QW-j]};
        assign ge = (t >= {1'b0, den_reg[j-1]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? DW'(t - {1'b0, den_reg[j-1]}) : t[DW-1:0];
                q_reg[j]   <= {q_reg[j-1][QW-2:0], ge};
                low_reg[j] <= low_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    // sign and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sat_reg[QW])
                res_reg <= neg_reg[QW] ? pws_pkg::OUT_MIN : pws_pkg::OUT_MAX;
            else if (neg_reg[QW])
                res_reg <= ({1'b0, q_reg[QW]} > {2'b01, {(QW-1){1'b0}}}) ?
                           pws_pkg::OUT_MIN : $signed(-q_reg[QW]);
            else
                res_reg <= ({1'b0, q_reg[QW]} > {2'b00, {(QW-1){1'b1}}}) ?
                           pws_pkg::OUT_MAX : $signed(q_reg[QW]);
        end
    end

    assign q = res_reg;

endmodule

// ===== hdl/perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
// perspective world-to-screen projection: each transaction on the input channel carries a
// world point in signed q16.16, multiplied by the 4x4 matrix held in eight 64-bit
// configuration registers (two q16.16 entries each, reset to identity). a point with
// clip w below 0.1 comes out with visible low and both coordinates at -1.0; otherwise
// x and y are divided by w and mapped to a SCREEN_WIDTH x SCREEN_HEIGHT viewport in
// signed q16.8, saturated. one point is accepted every cycle while the pipeline is not held.
// there are 31 register stages: five arithmetic stages, then the divider's input register,
// the 24-stage restoring divider (one quotient bit per stage) and the sign and clamp register.
// the divider sets most of the latency. the whole pipeline holds while a finished result is
// not taken. configuration writes are always accepted; indexes past seven are dropped.
module perspective_world_to_screen #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pws_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pws_pkg::out_t                out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pws_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [pws_pkg::CFG_DW-1:0]   cfg_data
);

    localparam int SW   = pws_pkg::SUM_W;
    localparam int MAGW = SW + 1;
    localparam int MHI  = MAGW - 32;
    localparam int KMAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int KW   = $clog2(128 * KMAX + 1);
    localparam int PW   = MAGW + KW;
    localparam int DW   = SW - 1;
    localparam int LAT  = 5 + pws_pkg::QW + 2;
    localparam logic [KW-1:0] KX = KW'(128 * SCREEN_WIDTH);
    localparam logic [KW-1:0] KY = KW'(128 * SCREEN_HEIGHT);

    // matrix registers
    logic [pws_pkg::CFG_DW-1:0] mat_reg [0:pws_pkg::NUM_REGS-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'd65536;
            mat_reg[1] <= 64'd0;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[3] <= 64'd0;
            mat_reg[4] <= 64'd0;
            mat_reg[5] <= 64'd65536;
            mat_reg[6] <= 64'd0;
            mat_reg[7] <= 64'h0001_0000_0000_0000;
        end
        else if (cfg_valid && (cfg_index < pws_pkg::CFG_IW'(pws_pkg::NUM_REGS)))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    logic signed [31:0] m [0:15];
    for (genvar n = 0; n < 16; n++)
    begin : g_ent
        assign m[n] = $signed(mat_reg[n/2][(n%2)*32 +: 32]);
    end

    // global advance: move whenever the last stage is empty or being drained
    logic en;
    logic v_reg   [0:LAT-1];
    logic vis_reg [2:LAT-1];

    assign en       = out_ready || !v_reg[LAT-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // stage 1: nine products
    logic signed [63:0] px_reg [0:2];
    logic signed [63:0] py_reg [0:2];
    logic signed [63:0] pz_reg [0:2];
    logic signed [31:0] cm_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                px_reg[c] <= in_data.pos_x * m[(c == 2) ? 3 : c];
                py_reg[c] <= in_data.pos_y * m[4 + ((c == 2) ? 3 : c)];
                pz_reg[c] <= in_data.pos_z * m[8 + ((c == 2) ? 3 : c)];
                cm_reg[c] <= m[12 + ((c == 2) ? 3 : c)];
            end
        end
    end

    // stage 2: floor to q16 and sum; rows are x, y, w
    logic signed [SW-1:0] clip_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                clip_reg[c] <= SW'(cm_reg[c]) + SW'($signed(px_reg[c][63:16]))
                             + SW'($signed(py_reg[c][63:16]))
                             + SW'($signed(pz_reg[c][63:16]));
        end
    end

    // stage 3: near test and numerators
    logic signed [MAGW-1:0] numx, numy;
    logic [MAGW-1:0] magx_reg, magy_reg;
    logic            negx_reg [3:4];
    logic            negy_reg [3:4];
    logic [DW-1:0]   den_reg  [3:4];

    assign numx = MAGW'(clip_reg[0]) + MAGW'(clip_reg[2]);
    assign numy = MAGW'(clip_reg[2]) - MAGW'(clip_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg[2]  <= (clip_reg[2] >= pws_pkg::NEAR_Q16);
            magx_reg    <= numx[MAGW-1] ? MAGW'(-numx) : MAGW'(numx);
            magy_reg    <= numy[MAGW-1] ? MAGW'(-numy) : MAGW'(numy);
            negx_reg[3] <= numx[MAGW-1];
            negy_reg[3] <= numy[MAGW-1];
            den_reg[3]  <= clip_reg[2][DW-1:0];
            for (int i = 3; i < LAT; i++)
                vis_reg[i] <= vis_reg[i-1];
        end
    end

    // stage 4: partial products by the viewport scale
    logic [32+KW-1:0]  ax_reg, ay_reg;
    logic [MHI+KW-1:0] bx_reg, by_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg      <= magx_reg[31:0] * KX;
            ay_reg      <= magy_reg[31:0] * KY;
            bx_reg      <= magx_reg[MAGW-1:32] * KX;
            by_reg      <= magy_reg[MAGW-1:32] * KY;
            negx_reg[4] <= negx_reg[3];
            negy_reg[4] <= negy_reg[3];
            den_reg[4]  <= den_reg[3];
        end
    end

    // stage 5: combine partial products
    logic [PW-1:0] prx_reg, pry_reg;
    logic [DW-1:0] den5_reg;
    logic          negx5_reg, negy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg   <= {bx_reg, 32'd0} + PW'(ax_reg);
            pry_reg   <= {by_reg, 32'd0} + PW'(ay_reg);
            den5_reg  <= den_reg[4];
            negx5_reg <= negx_reg[4];
            negy5_reg <= negy_reg[4];
        end
    end

    logic signed [pws_pkg::OUT_W-1:0] sx, sy;

    pws_divider #(.PW(PW), .DW(DW)) u_div_x (
        .clk  (clk),
        .en   (en),
        .prod (prx_reg),
        .den  (den5_reg),
        .neg  (negx5_reg),
        .q    (sx)
    );

    pws_divider #(.PW(PW), .DW(DW)) u_div_y (
        .clk  (clk),
        .en   (en),
        .prod (pry_reg),
        .den  (den5_reg),
        .neg  (negy5_reg),
        .q    (sy)
    );

    // hidden points ignore the divider result
    assign out_valid         = v_reg[LAT-1];
    assign out_data.visible  = vis_reg[LAT-1];
    assign out_data.screen_x = vis_reg[LAT-1] ? sx : pws_pkg::HIDDEN_VAL;
    assign out_data.screen_y = vis_reg[LAT-1] ? sy : pws_pkg::HIDDEN_VAL;

endmodule

// ===== hdl/pws_checker.sv =====
`timescale 1ns / 1ps
`include "perspective_world_to_screen_macros.svh"
module pws_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input pws_pkg::out_t out_data
);

    logic hidden_ok;
    assign hidden_ok = (out_data.screen_x == pws_pkg::HIDDEN_VAL)
                    && (out_data.screen_y == pws_pkg::HIDDEN_VAL);

    `PWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `PWS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "payload moved")
    `PWS_ASSERT_NOW(a_hidden, out_valid && !out_data.visible, hidden_ok, "hidden point moved")
    `PWS_ASSERT_NOW(a_ready, !out_valid || out_ready, in_ready, "input stalled without cause")

endmodule

bind perspective_world_to_screen pws_checker u_pws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
